>>> design/nca_pkg.sv
package nca_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int SEG_W   = 16;
  localparam int IDX_W   = 5;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int WORD_W  = 3 * COORD_W + SEG_W;

  // Item opcodes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;
    logic pt_load;
    logic scan_clr;
    logic scan_step;
    logic out_load;
  } nca_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_is_load;
    logic depth_zero;
    logic scan_last;
    logic pipe_busy;
    logic out_busy;
  } nca_sts_t;

  // Absolute difference of two signed Q16.16 values; always fits in 32 bits
  function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

>>> design/nca_chan_if.sv
interface nca_in_if import nca_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [IDX_W-1:0]          entry_index;
  logic signed [COORD_W-1:0] pt_depth;
  logic signed [COORD_W-1:0] pt_x;
  logic signed [COORD_W-1:0] pt_y;
  logic signed [SEG_W-1:0]   load_value;

  modport source(output valid, op, entry_index, pt_depth, pt_x, pt_y, load_value,
                 input ready);
  modport sink(input valid, op, entry_index, pt_depth, pt_x, pt_y, load_value,
               output ready);
endinterface

interface nca_out_if import nca_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SEG_W-1:0] seg_out;
  logic [IDX_W-1:0]        nearest_label;
  logic                    has_depth;

  modport source(output valid, seg_out, nearest_label, has_depth, input ready);
  modport sink(input valid, seg_out, nearest_label, has_depth, output ready);
endinterface

>>> design/nca_ram.sv
module nca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/nca_ctrl.sv
module nca_ctrl import nca_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  nca_sts_t sts,
  output nca_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Sequence one item: load, or scan every centroid (skipped for a zero depth) then post the result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.item_is_load) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.pt_load  = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt    = sts.depth_zero ? S_FINISH : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/nca_dp.sv
module nca_dp import nca_pkg::*; #(
  parameter int NUM_CLUSTERS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nca_cmd_t            cmd,
  output nca_sts_t            sts,
  input  logic                in_op,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [COORD_W-1:0]  in_pt_depth,
  input  logic [COORD_W-1:0]  in_pt_x,
  input  logic [COORD_W-1:0]  in_pt_y,
  input  logic [SEG_W-1:0]    in_load_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SEG_W-1:0]    out_seg_out,
  output logic [IDX_W-1:0]    out_nearest_label,
  output logic                out_has_depth
);

  localparam int AW = $clog2(NUM_CLUSTERS);

  // Centroid table
  logic              idx_ok;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [AW-1:0]     scan_r;

  // Held point
  logic [COORD_W-1:0] pd_r, px_r, py_r;
  logic               zero_r;

  // Pipeline stages
  logic               v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]      lbl1_r, lbl2_r, lbl3_r, lbl4_r;
  logic [SEG_W-1:0]   seg2_r, seg3_r, seg4_r;
  logic [COORD_W-1:0] ad_d_r, ad_x_r, ad_y_r;
  logic [SQ_W-1:0]    sq_d_r, sq_x_r, sq_y_r;
  logic [DIST_W-1:0]  sum_r;

  // Running best
  logic [DIST_W-1:0]  best_d_r;
  logic [AW-1:0]      best_lbl_r;
  logic [SEG_W-1:0]   best_seg_r;
  logic               take_best;

  // Output register
  logic               out_valid_r;
  logic [SEG_W-1:0]   out_seg_r;
  logic [IDX_W-1:0]   out_lbl_r;
  logic               out_hd_r;

  assign idx_ok    = 32'(in_entry_index) < NUM_CLUSTERS;
  assign ram_we    = cmd.wr_en && idx_ok;
  assign ram_wdata = {in_load_value, in_pt_y, in_pt_x, in_pt_depth};

  nca_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_CLUSTERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_index)),
    .wdata (ram_wdata),
    .re    (cmd.scan_step),
    .raddr (scan_r),
    .rdata (ram_rdata)
  );

  // Advance the scan address
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + 1'b1;
    end
  end

  // Hold the point being classified
  always_ff @(posedge clk) begin
    if (cmd.pt_load) begin
      pd_r   <= in_pt_depth;
      px_r   <= in_pt_x;
      py_r   <= in_pt_y;
      zero_r <= (in_pt_depth == '0);
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_step;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Absolute differences, squares, then the sum of squares
  always_ff @(posedge clk) begin
    lbl1_r <= scan_r;
    lbl2_r <= lbl1_r;
    seg2_r <= ram_rdata[WORD_W-1 -: SEG_W];
    ad_d_r <= abs_diff(pd_r, ram_rdata[0 +: COORD_W]);
    ad_x_r <= abs_diff(px_r, ram_rdata[COORD_W +: COORD_W]);
    ad_y_r <= abs_diff(py_r, ram_rdata[2*COORD_W +: COORD_W]);
    lbl3_r <= lbl2_r;
    seg3_r <= seg2_r;
    sq_d_r <= SQ_W'(ad_d_r) * SQ_W'(ad_d_r);
    sq_x_r <= SQ_W'(ad_x_r) * SQ_W'(ad_x_r);
    sq_y_r <= SQ_W'(ad_y_r) * SQ_W'(ad_y_r);
    lbl4_r <= lbl3_r;
    seg4_r <= seg3_r;
    sum_r  <= DIST_W'(sq_d_r) + DIST_W'(sq_x_r) + DIST_W'(sq_y_r);
  end

  // Keep the first centroid, then only strictly nearer ones
  assign take_best = v4_r && ((lbl4_r == '0) || (sum_r < best_d_r));

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_d_r   <= sum_r;
      best_lbl_r <= lbl4_r;
      best_seg_r <= seg4_r;
    end
  end

  // Output register, freed when the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_seg_r <= zero_r ? '0 : best_seg_r;
      out_lbl_r <= zero_r ? '0 : IDX_W'(best_lbl_r);
      out_hd_r  <= !zero_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_seg_out       = out_seg_r;
  assign out_nearest_label = out_lbl_r;
  assign out_has_depth     = out_hd_r;

  assign sts.item_is_load = (in_op == OP_LOAD);
  assign sts.depth_zero   = (in_pt_depth == '0);
  assign sts.scan_last    = (scan_r == AW'(NUM_CLUSTERS - 1));
  assign sts.pipe_busy    = v1_r || v2_r || v3_r || v4_r;
  assign sts.out_busy     = out_valid_r && !out_ready;

endmodule

>>> design/nearest_centroid_label_assign.sv
// Load item: written to the centroid table when accepted, unless entry_index is out of range; no result.
// Classify item: one centroid read per cycle through a four-stage distance pipeline,
//   keeping the nearest; the result is posted once the pipeline drains and the output is free.
// Zero depth skips the scan and gives label 0, value 0. A new item is taken only when idle.
// Reset clears the controller, pipeline valids and output valid; the centroid table
//   is undefined until loaded and has no clearing pass.
module nearest_centroid_label_assign import nca_pkg::*; #(
  parameter int NUM_CLUSTERS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  nca_in_if.sink          in_chan,
  nca_out_if.source       out_chan
);

  nca_cmd_t cmd;
  nca_sts_t sts;

  nca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nca_dp #(
    .NUM_CLUSTERS (NUM_CLUSTERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_chan.op),
    .in_entry_index    (in_chan.entry_index),
    .in_pt_depth       (in_chan.pt_depth),
    .in_pt_x           (in_chan.pt_x),
    .in_pt_y           (in_chan.pt_y),
    .in_load_value     (in_chan.load_value),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_seg_out       (out_chan.seg_out),
    .out_nearest_label (out_chan.nearest_label),
    .out_has_depth     (out_chan.has_depth)
  );

  // Table writes never overlap a scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.scan_step))
    else $error("table write during scan");

  // No new item is taken while scanning
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !in_chan.ready)
    else $error("input ready during scan");

  // A result is never posted over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_chan.valid && !out_chan.ready))
    else $error("result overwritten");

  // A posted result shows up as valid next cycle
  a_out_posted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_chan.valid)
    else $error("result not posted");

endmodule
